// ===== rtl/core/sti_pkg.sv =====
// ----------------------------------------------------------------------------
// sti_pkg: shared types and constants of the sorted table
// Request, result and cell token layouts, operation and error codes.
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int INDEX_WIDTH = 6;
  localparam int COUNT_WIDTH = 7;

  // Register index of order_mode, as seen on paddr[2].
  localparam logic REG_ORDER_MODE = 1'b0;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_SEARCH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_INDEX = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef struct packed {
    kind_t                          kind;
    logic signed [VALUE_WIDTH-1:0]  value;
    logic        [INDEX_WIDTH-1:0]  index;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0]  data_out;
    logic        [INDEX_WIDTH-1:0]  position;
    logic                           found;
    logic        [1:0]              error_code;
    logic        [COUNT_WIDTH-1:0]  entry_count;
    logic                           is_empty;
  } rsp_t;

  // Operation token that walks down the row of cells, one cell per cycle.
  typedef struct packed {
    logic                           active;
    kind_t                          kind;
    logic signed [VALUE_WIDTH-1:0]  value;
    logic        [INDEX_WIDTH-1:0]  index;
    logic                           placed;
    logic                           found;
    logic        [INDEX_WIDTH-1:0]  position;
    logic signed [VALUE_WIDTH-1:0]  data;
  } tok_t;

endpackage

// ===== rtl/core/sti_cell.sv =====
// ----------------------------------------------------------------------------
// sti_cell: one slot of the sorted table
// Holds one entry and applies the passing operation token to it.
// ----------------------------------------------------------------------------
module sti_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic [sti_pkg::COUNT_WIDTH-1:0]          count,
  input  logic                                     order_mode,
  input  sti_pkg::tok_t                            tok_in,
  input  logic signed [sti_pkg::VALUE_WIDTH-1:0]   right_value,
  output sti_pkg::tok_t                            tok_out,
  output logic signed [sti_pkg::VALUE_WIDTH-1:0]   value_out
);

  localparam logic [sti_pkg::COUNT_WIDTH-1:0] MY_SLOT  = sti_pkg::COUNT_WIDTH'(CELL_IDX);
  localparam logic [sti_pkg::INDEX_WIDTH-1:0] MY_INDEX = sti_pkg::INDEX_WIDTH'(CELL_IDX);

  logic signed [sti_pkg::VALUE_WIDTH-1:0] stored;
  logic signed [sti_pkg::VALUE_WIDTH-1:0] stored_next;
  sti_pkg::tok_t                          tok_next;
  logic                                   occupied;
  logic                                   precedes;

  assign occupied  = (MY_SLOT < count);
  assign precedes  = order_mode ? (tok_in.value >= stored) : (tok_in.value <= stored);
  assign value_out = stored;

  always_comb begin
    tok_next    = tok_in;
    stored_next = stored;
    if (tok_in.active) begin
      case (tok_in.kind)
        sti_pkg::KIND_INSERT: begin
          // Once the new value has found its slot, every later cell swaps.
          if (tok_in.placed || !occupied || precedes) begin
            stored_next     = tok_in.value;
            tok_next.value  = stored;
            tok_next.placed = 1'b1;
          end
        end
        sti_pkg::KIND_REMOVE: begin
          if (tok_in.index == MY_INDEX) begin
            tok_next.data = stored;
          end
          if (tok_in.index <= MY_INDEX) begin
            stored_next = right_value;
          end
        end
        sti_pkg::KIND_READ: begin
          if (tok_in.index == MY_INDEX) begin
            tok_next.data = stored;
          end
        end
        sti_pkg::KIND_SEARCH: begin
          if (!tok_in.found && occupied && (tok_in.value == stored)) begin
            tok_next.found    = 1'b1;
            tok_next.position = MY_INDEX;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    stored <= stored_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== rtl/core/sorted_table_with_index_access.sv =====
// ----------------------------------------------------------------------------
// sorted_table_with_index_access: sorted table with index access
// Row of cells holding up to CAPACITY signed entries in configured order.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                        Payload
//  --------  ---------  -------------------------------  -----------------
//  request   in         start high while busy low        request (req_t)
//  result    out        done, one cycle, cannot stall    result (rsp_t)
//  config    in         APB write, pready always high    paddr, pwdata
//
// A request that fails its checks (index not below the count, insert into a
// full table) is answered with done in the next cycle and never sets busy.
// Any other request sends a token through all CAPACITY cells, one cell per
// cycle; done is registered from the token that leaves the last cell, and busy
// falls in that same cycle, so the next request may be accepted at the edge
// that ends the done cycle. The length of the cell row sets how long a pass
// takes. Reset clears the count, the order mode and the token valid flags;
// the stored entries are undefined until written. The result is shown for
// one cycle only, since the receiver cannot stall.
//
module sorted_table_with_index_access (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  sti_pkg::req_t        request,
  output logic                 done,
  output sti_pkg::rsp_t        result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam logic [sti_pkg::COUNT_WIDTH-1:0] FULL_COUNT =
    sti_pkg::COUNT_WIDTH'(sti_pkg::CAPACITY);

  // Configuration register. The byte offset bits of paddr are ignored.
  logic order_mode;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == sti_pkg::REG_ORDER_MODE) ? {31'b0, order_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == sti_pkg::REG_ORDER_MODE)) begin
      order_mode <= pwdata[0];
    end
  end

  // Token chain: tok[0] carries the injection register, tok[i+1] leaves cell i.
  sti_pkg::tok_t                          tok [0:sti_pkg::CAPACITY];
  logic signed [sti_pkg::VALUE_WIDTH-1:0] cell_value [0:sti_pkg::CAPACITY-1];
  logic [sti_pkg::COUNT_WIDTH-1:0]        count;
  sti_pkg::tok_t                          inject;

  assign tok[0] = inject;

  genvar gi;
  generate
    for (gi = 0; gi < sti_pkg::CAPACITY; gi++) begin : g_cell
      logic signed [sti_pkg::VALUE_WIDTH-1:0] right_value;
      if (gi == sti_pkg::CAPACITY - 1) begin : g_last
        // The last cell has no right neighbor; a remove leaves it unchanged.
        assign right_value = cell_value[gi];
      end else begin : g_mid
        assign right_value = cell_value[gi+1];
      end
      sti_cell #(
        .CELL_IDX (gi)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .count       (count),
        .order_mode  (order_mode),
        .tok_in      (tok[gi]),
        .right_value (right_value),
        .tok_out     (tok[gi+1]),
        .value_out   (cell_value[gi])
      );
    end
  endgenerate

  // Request checks done up front, so that a failing request needs no pass.
  logic         accept;
  sti_pkg::err_t req_err;

  assign accept = start && !busy;

  always_comb begin
    req_err = sti_pkg::ERR_OK;
    case (request.kind)
      sti_pkg::KIND_INSERT: begin
        if (count >= FULL_COUNT) begin
          req_err = sti_pkg::ERR_FULL;
        end
      end
      sti_pkg::KIND_REMOVE, sti_pkg::KIND_READ: begin
        if (sti_pkg::COUNT_WIDTH'(request.index) >= count) begin
          req_err = sti_pkg::ERR_INDEX;
        end
      end
      default: begin
      end
    endcase
  end

  // Count after the token that leaves the last cell.
  sti_pkg::tok_t                   tail;
  logic [sti_pkg::COUNT_WIDTH-1:0] count_next;

  assign tail = tok[sti_pkg::CAPACITY];

  always_comb begin
    count_next = count;
    case (tail.kind)
      sti_pkg::KIND_INSERT: count_next = count + 1'b1;
      sti_pkg::KIND_REMOVE: count_next = count - 1'b1;
      default:              count_next = count;
    endcase
  end

  // Control: busy, done, count and the injected token. The token payload
  // needs no reset; only its valid flag is cleared.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      done          <= 1'b0;
      count         <= '0;
      inject.active <= 1'b0;
    end else begin
      done          <= tail.active || (accept && (req_err != sti_pkg::ERR_OK));
      inject.active <= !tail.active && accept && (req_err == sti_pkg::ERR_OK);
      if (tail.active) begin
        busy  <= 1'b0;
        count <= count_next;
      end else if (accept && (req_err == sti_pkg::ERR_OK)) begin
        busy  <= 1'b1;
      end
      if (accept) begin
        inject.kind     <= request.kind;
        inject.value    <= request.value;
        inject.index    <= request.index;
        inject.placed   <= 1'b0;
        inject.found    <= 1'b0;
        inject.position <= '0;
        inject.data     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.active) begin
      result.data_out    <= tail.data;
      result.position    <= tail.position;
      result.found       <= tail.found;
      result.error_code  <= sti_pkg::ERR_OK;
      result.entry_count <= count_next;
      result.is_empty    <= (count_next == '0);
    end else if (accept) begin
      // Only a failing request reports here; a passing one is overwritten
      // when its token leaves the row.
      result.data_out    <= '0;
      result.position    <= '0;
      result.found       <= 1'b0;
      result.error_code  <= req_err;
      result.entry_count <= count;
      result.is_empty    <= (count == '0);
    end
  end

endmodule

// ===== rtl/core/sti_checker.sv =====
// ----------------------------------------------------------------------------
// sti_checker: port-level checks of the sorted table
// Watches the request and result ports over time.
// ----------------------------------------------------------------------------
module sti_checker (
  input logic          clk,
  input logic          rst,
  input logic          busy,
  input logic          done,
  input sti_pkg::rsp_t result
);

  // A pass through the cells always ends with a result.
  a_busy_ends_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy fell without a result");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.is_empty == (result.entry_count == '0)))
    else $error("is_empty disagrees with entry_count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.entry_count <= sti_pkg::COUNT_WIDTH'(sti_pkg::CAPACITY)))
    else $error("entry_count above capacity");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (result.error_code != sti_pkg::ERR_OK)) |->
      ((result.data_out == '0) && !result.found))
    else $error("failed request carries data");

  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    (done && result.found) |->
      (sti_pkg::COUNT_WIDTH'(result.position) < result.entry_count))
    else $error("search position beyond stored entries");

endmodule

bind sorted_table_with_index_access sti_checker u_sti_checker (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .done   (done),
  .result (result)
);
